// ----- hw/rtl/tqse_pkg.sv -----
// Shared types, constants and the saturation helper function of the transition quad shape evaluator.
package tqse_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 17;
  localparam int MASK_W    = 8;
  localparam int IDX_W     = 3;
  localparam int MIDS      = 4;

  // Width of the difference terms (1 -/+ coordinate) and of the quadratic bubbles.
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 18;
  // Coordinate times difference, truncated back to the fixed-point grid.
  localparam int FX_W   = 19;
  // Bilinear product, quartered.
  localparam int BQ_W   = 18;
  // Midside shape value and derivatives after masking.
  localparam int NM_W   = 19;
  localparam int DM_W   = 20;
  // Quartered difference terms used in the corner derivatives.
  localparam int QT_W   = DIFF_W - 2;
  // Working width of the corner combination before saturation.
  localparam int ACC_W  = 22;

  localparam logic signed [DIFF_W-1:0] ONE     = DIFF_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  OUT_MAX = ACC_W'(65535);
  localparam logic signed [ACC_W-1:0]  OUT_MIN = -ACC_W'(65536);

  // Products and differences handed from the polynomial stages to the node stage.
  typedef struct packed {
    logic [MASK_W-1:0]                 mask;
    logic signed [DIFF_W-1:0]          omx;
    logic signed [DIFF_W-1:0]          opx;
    logic signed [DIFF_W-1:0]          ome;
    logic signed [DIFF_W-1:0]          ope;
    logic signed [DIFF_W-1:0]          qx;
    logic signed [DIFF_W-1:0]          qe;
    logic signed [FX_W-1:0]            fx_ome;
    logic signed [FX_W-1:0]            fx_ope;
    logic signed [FX_W-1:0]            fe_opx;
    logic signed [FX_W-1:0]            fe_omx;
    logic [MIDS-1:0][BQ_W-1:0]         bq;
  } poly_t;

  // Saturated results of all eight nodes of one request.
  typedef struct packed {
    logic [MASK_W-1:0]                 mask;
    logic [MASK_W-1:0][OUT_W-1:0]      shape;
    logic [MASK_W-1:0][OUT_W-1:0]      dxi;
    logic [MASK_W-1:0][OUT_W-1:0]      deta;
  } node_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/transition_quad_shape_eval_unit.sv -----
// Top level of the transition quad shape evaluator: three arithmetic stages and a serialiser.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   xi_coord_i, eta_coord_i, node_mask_i
//   out      output     out_valid_o/out_ready_i node_number_o, shape_value_o, deriv_xi_o,
//                                               deriv_eta_o, last_node_o
//
// A request passes three register stages, the result buffer and the output register.
// The serialiser sends one result per cycle while the output is not stalled; an empty
// mask sends nothing but still passes through the result buffer.
// Stages advance independently with their own valid bits; a stalled output holds
// every stage behind it. Reset clears all valid bits and the pending node mask.
module transition_quad_shape_eval_unit import tqse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] xi_coord_i,
  input  logic signed [COORD_W-1:0] eta_coord_i,
  input  logic [MASK_W-1:0]         node_mask_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_W-1:0]          node_number_o,
  output logic signed [OUT_W-1:0]   shape_value_o,
  output logic signed [OUT_W-1:0]   deriv_xi_o,
  output logic signed [OUT_W-1:0]   deriv_eta_o,
  output logic                      last_node_o
);

  logic  poly_valid, poly_ready;
  poly_t poly;
  logic  node_valid, node_ready;
  node_t node;

  tqse_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .xi_i    (xi_coord_i),
    .eta_i   (eta_coord_i),
    .mask_i  (node_mask_i),
    .valid_o (poly_valid),
    .ready_i (poly_ready),
    .poly_o  (poly)
  );

  tqse_node u_node (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (poly_valid),
    .ready_o (poly_ready),
    .poly_i  (poly),
    .valid_o (node_valid),
    .ready_i (node_ready),
    .node_o  (node)
  );

  tqse_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (node_valid),
    .ready_o       (node_ready),
    .node_i        (node),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .node_number_o (node_number_o),
    .shape_value_o (shape_value_o),
    .deriv_xi_o    (deriv_xi_o),
    .deriv_eta_o   (deriv_eta_o),
    .last_node_o   (last_node_o)
  );

endmodule

// ----- hw/rtl/tqse_poly.sv -----
// First two pipeline stages: difference terms, squares, bubbles and the coordinate and bilinear products.
module tqse_poly import tqse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [COORD_W-1:0] xi_i,
  input  logic signed [COORD_W-1:0] eta_i,
  input  logic [MASK_W-1:0]         mask_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output poly_t                     poly_o
);

  logic                      s1_valid_q;
  logic                      s1_ready;
  logic signed [COORD_W-1:0] x_q, e_q;
  logic [MASK_W-1:0]         mask_q;
  logic signed [DIFF_W-1:0]  omx_q, opx_q, ome_q, ope_q;
  logic signed [DIFF_W-1:0]  omx_d, opx_d, ome_d, ope_d;
  logic signed [SQ_W-1:0]    xs_q, es_q;
  logic signed [SQ_W-1:0]    xs_d, es_d;
  logic signed [31:0]        xx, ee;

  logic                      s2_valid_q;
  logic                      s2_ready;
  poly_t                     poly_q;
  poly_t                     poly_d;
  logic signed [32:0]        p_xome, p_xope, p_eopx, p_eomx;
  logic signed [33:0]        p_b0, p_b1, p_b2, p_b3;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_valid_q;
  assign poly_o   = poly_q;

  // Stage one: differences and squares.
  always_comb begin
    omx_d = ONE - DIFF_W'(xi_i);
    opx_d = ONE + DIFF_W'(xi_i);
    ome_d = ONE - DIFF_W'(eta_i);
    ope_d = ONE + DIFF_W'(eta_i);
    xx    = 32'(xi_i) * 32'(xi_i);
    ee    = 32'(eta_i) * 32'(eta_i);
    xs_d  = SQ_W'(xx >>> FRAC_BITS);
    es_d  = SQ_W'(ee >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      x_q    <= xi_i;
      e_q    <= eta_i;
      mask_q <= mask_i;
      omx_q  <= omx_d;
      opx_q  <= opx_d;
      ome_q  <= ome_d;
      ope_q  <= ope_d;
      xs_q   <= xs_d;
      es_q   <= es_d;
    end
  end

  // Stage two: bubbles and the eight independent products.
  always_comb begin
    p_xome = 33'(x_q) * 33'(ome_q);
    p_xope = 33'(x_q) * 33'(ope_q);
    p_eopx = 33'(e_q) * 33'(opx_q);
    p_eomx = 33'(e_q) * 33'(omx_q);
    p_b0   = 34'(omx_q) * 34'(ome_q);
    p_b1   = 34'(opx_q) * 34'(ome_q);
    p_b2   = 34'(opx_q) * 34'(ope_q);
    p_b3   = 34'(omx_q) * 34'(ope_q);

    poly_d.mask   = mask_q;
    poly_d.omx    = omx_q;
    poly_d.opx    = opx_q;
    poly_d.ome    = ome_q;
    poly_d.ope    = ope_q;
    poly_d.qx     = DIFF_W'(SQ_W'(ONE) - xs_q);
    poly_d.qe     = DIFF_W'(SQ_W'(ONE) - es_q);
    poly_d.fx_ome = FX_W'(p_xome >>> FRAC_BITS);
    poly_d.fx_ope = FX_W'(p_xope >>> FRAC_BITS);
    poly_d.fe_opx = FX_W'(p_eopx >>> FRAC_BITS);
    poly_d.fe_omx = FX_W'(p_eomx >>> FRAC_BITS);
    // Truncating by FRAC_BITS and then quartering is one shift by FRAC_BITS + 2.
    poly_d.bq[0]  = BQ_W'(p_b0 >>> (FRAC_BITS + 2));
    poly_d.bq[1]  = BQ_W'(p_b1 >>> (FRAC_BITS + 2));
    poly_d.bq[2]  = BQ_W'(p_b2 >>> (FRAC_BITS + 2));
    poly_d.bq[3]  = BQ_W'(p_b3 >>> (FRAC_BITS + 2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      poly_q <= poly_d;
    end
  end

endmodule

// ----- hw/rtl/tqse_node.sv -----
// Third pipeline stage: midside terms, then the corner corrections and saturation.
module tqse_node import tqse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  poly_t poly_i,
  output logic  valid_o,
  input  logic  ready_i,
  output node_t node_o
);

  logic                            s3_valid_q;
  logic                            s3_ready;
  logic [MASK_W-1:0]               mask_q;
  logic [MIDS-1:0][NM_W-1:0]       nm_q, nm_d;
  logic [MIDS-1:0][DM_W-1:0]       dxm_q, dxm_d;
  logic [MIDS-1:0][DM_W-1:0]       dem_q, dem_d;
  logic [MIDS-1:0][BQ_W-1:0]       bq_q;
  logic signed [QT_W-1:0]          qomx_q, qopx_q, qome_q, qope_q;
  logic signed [33:0]              p_n4, p_n5, p_n6, p_n7;
  logic signed [DIFF_W-2:0]        hqx, hqe;

  logic signed [ACC_W-1:0]         cdx [MIDS];
  logic signed [ACC_W-1:0]         cde [MIDS];
  logic signed [ACC_W-1:0]         nsum, dxsum, desum;
  logic signed [ACC_W-1:0]         acc_n, acc_dx, acc_de;

  assign s3_ready = !s3_valid_q || ready_i;
  assign ready_o  = s3_ready;
  assign valid_o  = s3_valid_q;

  always_comb begin
    p_n4 = 34'(poly_i.qx) * 34'(poly_i.ome);
    p_n5 = 34'(poly_i.qe) * 34'(poly_i.opx);
    p_n6 = 34'(poly_i.qx) * 34'(poly_i.ope);
    p_n7 = 34'(poly_i.qe) * 34'(poly_i.omx);
    hqx  = (DIFF_W-1)'(poly_i.qx >>> 1);
    hqe  = (DIFF_W-1)'(poly_i.qe >>> 1);

    // Truncating by FRAC_BITS and then halving is one shift by FRAC_BITS + 1.
    nm_d[0]  = NM_W'(p_n4 >>> (FRAC_BITS + 1));
    nm_d[1]  = NM_W'(p_n5 >>> (FRAC_BITS + 1));
    nm_d[2]  = NM_W'(p_n6 >>> (FRAC_BITS + 1));
    nm_d[3]  = NM_W'(p_n7 >>> (FRAC_BITS + 1));
    dxm_d[0] = -DM_W'(poly_i.fx_ome);
    dem_d[0] = -DM_W'(hqx);
    dxm_d[1] =  DM_W'(hqe);
    dem_d[1] = -DM_W'(poly_i.fe_opx);
    dxm_d[2] = -DM_W'(poly_i.fx_ope);
    dem_d[2] =  DM_W'(hqx);
    dxm_d[3] = -DM_W'(hqe);
    dem_d[3] = -DM_W'(poly_i.fe_omx);

    // An absent midside node contributes nothing to the corners.
    for (int m = 0; m < MIDS; m++) begin
      if (!poly_i.mask[MIDS + m]) begin
        nm_d[m]  = '0;
        dxm_d[m] = '0;
        dem_d[m] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      mask_q <= poly_i.mask;
      nm_q   <= nm_d;
      dxm_q  <= dxm_d;
      dem_q  <= dem_d;
      bq_q   <= poly_i.bq;
      qomx_q <= QT_W'(poly_i.omx >>> 2);
      qopx_q <= QT_W'(poly_i.opx >>> 2);
      qome_q <= QT_W'(poly_i.ome >>> 2);
      qope_q <= QT_W'(poly_i.ope >>> 2);
    end
  end

  // Corner combination: bilinear quarter minus half the two adjacent midside terms.
  always_comb begin
    cdx[0] = -ACC_W'(qome_q);
    cde[0] = -ACC_W'(qomx_q);
    cdx[1] =  ACC_W'(qome_q);
    cde[1] = -ACC_W'(qopx_q);
    cdx[2] =  ACC_W'(qope_q);
    cde[2] =  ACC_W'(qopx_q);
    cdx[3] = -ACC_W'(qope_q);
    cde[3] =  ACC_W'(qomx_q);

    node_o.mask = mask_q;
    nsum   = '0;
    dxsum  = '0;
    desum  = '0;
    acc_n  = '0;
    acc_dx = '0;
    acc_de = '0;
    for (int c = 0; c < MIDS; c++) begin
      nsum   = ACC_W'($signed(nm_q[2'(c + 3)]))  + ACC_W'($signed(nm_q[c]));
      dxsum  = ACC_W'($signed(dxm_q[2'(c + 3)])) + ACC_W'($signed(dxm_q[c]));
      desum  = ACC_W'($signed(dem_q[2'(c + 3)])) + ACC_W'($signed(dem_q[c]));
      acc_n  = ACC_W'($signed(bq_q[c])) - (nsum >>> 1);
      acc_dx = cdx[c] - (dxsum >>> 1);
      acc_de = cde[c] - (desum >>> 1);
      node_o.shape[c] = sat_out(acc_n);
      node_o.dxi[c]   = sat_out(acc_dx);
      node_o.deta[c]  = sat_out(acc_de);
      node_o.shape[MIDS + c] = sat_out(ACC_W'($signed(nm_q[c])));
      node_o.dxi[MIDS + c]   = sat_out(ACC_W'($signed(dxm_q[c])));
      node_o.deta[MIDS + c]  = sat_out(ACC_W'($signed(dem_q[c])));
    end
  end

endmodule

// ----- hw/rtl/tqse_serial.sv -----
// Result buffer and output register that hand out one present node per cycle while the output is not stalled.
module tqse_serial import tqse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  node_t                   node_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        node_number_o,
  output logic signed [OUT_W-1:0] shape_value_o,
  output logic signed [OUT_W-1:0] deriv_xi_o,
  output logic signed [OUT_W-1:0] deriv_eta_o,
  output logic                    last_node_o
);

  node_t             buf_q;
  logic [MASK_W-1:0] rem_q, rem_d;
  logic [MASK_W-1:0] rem_clr;
  logic [IDX_W-1:0]  idx;
  logic              load;
  logic              take;

  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  num_q;
  logic [OUT_W-1:0]  shape_q, dxi_q, deta_q;
  logic              last_q;

  // Lowest outstanding node goes out next.
  always_comb begin
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign rem_clr = rem_q & (rem_q - MASK_W'(1));
  assign load    = (rem_q != '0) && (!out_valid_q || out_ready_i);
  // A request with an empty mask passes through the buffer without a result.
  assign ready_o = (rem_q == '0) || (load && rem_clr == '0);
  assign take    = valid_i && ready_o;

  always_comb begin
    rem_d = rem_q;
    if (take) begin
      rem_d = node_i.mask;
    end else if (load) begin
      rem_d = rem_clr;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q <= node_i;
    end
    if (load) begin
      num_q   <= idx;
      shape_q <= buf_q.shape[idx];
      dxi_q   <= buf_q.dxi[idx];
      deta_q  <= buf_q.deta[idx];
      last_q  <= (rem_clr == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign node_number_o = num_q;
  assign shape_value_o = $signed(shape_q);
  assign deriv_xi_o    = $signed(dxi_q);
  assign deriv_eta_o   = $signed(deta_q);
  assign last_node_o   = last_q;

endmodule

// ----- hw/rtl/tqse_checker.sv -----
// Port-level checker for the transition quad shape evaluator, bound to the top level.
module tqse_checker import tqse_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [COORD_W-1:0] xi_coord_i,
  input logic signed [COORD_W-1:0] eta_coord_i,
  input logic [MASK_W-1:0]         node_mask_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [IDX_W-1:0]          node_number_o,
  input logic signed [OUT_W-1:0]   shape_value_o,
  input logic signed [OUT_W-1:0]   deriv_xi_o,
  input logic signed [OUT_W-1:0]   deriv_eta_o,
  input logic                      last_node_o
);

  logic             in_acc, out_acc;
  logic [3:0]       pending_q;
  logic             mid_item_q;
  logic [IDX_W-1:0] prev_num_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Requests with at least one present node whose last result is still to come.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      mid_item_q <= 1'b0;
      prev_num_q <= '0;
    end else begin
      pending_q <= pending_q + 4'((in_acc && node_mask_i != '0) ? 1 : 0)
                             - 4'((out_acc && last_node_o) ? 1 : 0);
      if (out_acc) begin
        mid_item_q <= !last_node_o;
        prev_num_q <= node_number_o;
      end
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(xi_coord_i) &&
      $stable(eta_coord_i) && $stable(node_mask_i))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(node_number_o) &&
      $stable(shape_value_o) && $stable(deriv_xi_o) && $stable(deriv_eta_o) &&
      $stable(last_node_o))
    else $error("result changed while stalled");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_item_q |-> node_number_o > prev_num_q)
    else $error("node numbers not ascending within a request");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an outstanding request");

  a_no_empty_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == '0 |=> !out_valid_o || $past(in_acc))
    else $error("result appeared with nothing outstanding");

endmodule

bind transition_quad_shape_eval_unit tqse_checker u_tqse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .xi_coord_i    (xi_coord_i),
  .eta_coord_i   (eta_coord_i),
  .node_mask_i   (node_mask_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .node_number_o (node_number_o),
  .shape_value_o (shape_value_o),
  .deriv_xi_o    (deriv_xi_o),
  .deriv_eta_o   (deriv_eta_o),
  .last_node_o   (last_node_o)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench of the transition quad shape evaluator, with its own node predictor.
`timescale 1ns / 1ps

module tb_top import tqse_pkg::*; ();

  typedef struct {
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] eta;
    logic [MASK_W-1:0]         mask;
  } coord_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [OUT_W-1:0] shape;
    logic [OUT_W-1:0] dxi;
    logic [OUT_W-1:0] deta;
    logic             last;
  } node_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] xi_coord_i = '0;
  logic signed [COORD_W-1:0] eta_coord_i = '0;
  logic [MASK_W-1:0]         node_mask_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [IDX_W-1:0]          node_number_o;
  logic signed [OUT_W-1:0]   shape_value_o;
  logic signed [OUT_W-1:0]   deriv_xi_o;
  logic signed [OUT_W-1:0]   deriv_eta_o;
  logic                      last_node_o;

  coord_req_t   req_queue[$];
  node_result_t expected_nodes[$];
  coord_req_t   next_req;
  node_result_t got_node;
  node_result_t want_node;
  int           accepted_reqs = 0;
  int           mismatch_cnt = 0;
  logic         calm;

  transition_quad_shape_eval_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .xi_coord_i   (xi_coord_i),
    .eta_coord_i  (eta_coord_i),
    .node_mask_i  (node_mask_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .node_number_o(node_number_o),
    .shape_value_o(shape_value_o),
    .deriv_xi_o   (deriv_xi_o),
    .deriv_eta_o  (deriv_eta_o),
    .last_node_o  (last_node_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A stretch of requests during which neither side pauses.
  assign calm = (accepted_reqs >= 60) && (accepted_reqs < 95);

  function automatic longint q_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] clip_q3(input longint v);
    longint c;
    c = v;
    if (c > 65535) begin
      c = 65535;
    end else if (c < -65536) begin
      c = -65536;
    end
    return c[OUT_W-1:0];
  endfunction

  // Works out every node of one request and queues the present ones in node order.
  task automatic predict_nodes(input logic signed [COORD_W-1:0] xi,
                               input logic signed [COORD_W-1:0] eta,
                               input logic [MASK_W-1:0] mask);
    longint one, x, e, omx, opx, ome, ope, qx, qe;
    longint n[8];
    longint dx[8];
    longint de[8];
    int last_i;
    node_result_t r;
    one = longint'(1) << FRAC_BITS;
    x = xi;
    e = eta;
    omx = one - x;
    opx = one + x;
    ome = one - e;
    ope = one + e;
    qx = one - q_mul(x, x);
    qe = one - q_mul(e, e);

    n[4] = q_mul(qx, ome) >>> 1;
    n[5] = q_mul(qe, opx) >>> 1;
    n[6] = q_mul(qx, ope) >>> 1;
    n[7] = q_mul(qe, omx) >>> 1;
    dx[4] = -q_mul(x, ome);
    de[4] = -(qx >>> 1);
    dx[5] = qe >>> 1;
    de[5] = -q_mul(e, opx);
    dx[6] = -q_mul(x, ope);
    de[6] = qx >>> 1;
    dx[7] = -(qe >>> 1);
    de[7] = -q_mul(e, omx);
    // Missing midside nodes drop out of the corner corrections.
    for (int i = 4; i < 8; i++) begin
      if (!mask[i]) begin
        n[i] = 0;
        dx[i] = 0;
        de[i] = 0;
      end
    end

    n[0] = (q_mul(omx, ome) >>> 2) - ((n[7] + n[4]) >>> 1);
    n[1] = (q_mul(opx, ome) >>> 2) - ((n[4] + n[5]) >>> 1);
    n[2] = (q_mul(opx, ope) >>> 2) - ((n[5] + n[6]) >>> 1);
    n[3] = (q_mul(omx, ope) >>> 2) - ((n[6] + n[7]) >>> 1);

    dx[0] = -(ome >>> 2) - ((dx[7] + dx[4]) >>> 1);
    de[0] = -(omx >>> 2) - ((de[7] + de[4]) >>> 1);
    dx[1] = (ome >>> 2) - ((dx[4] + dx[5]) >>> 1);
    de[1] = -(opx >>> 2) - ((de[4] + de[5]) >>> 1);
    dx[2] = (ope >>> 2) - ((dx[5] + dx[6]) >>> 1);
    de[2] = (opx >>> 2) - ((de[5] + de[6]) >>> 1);
    dx[3] = -(ope >>> 2) - ((dx[6] + dx[7]) >>> 1);
    de[3] = (omx >>> 2) - ((de[6] + de[7]) >>> 1);

    last_i = -1;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        last_i = i;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        r.node = i[IDX_W-1:0];
        r.shape = clip_q3(n[i]);
        r.dxi = clip_q3(dx[i]);
        r.deta = clip_q3(de[i]);
        r.last = (i == last_i);
        expected_nodes.push_back(r);
      end
    end
  endtask

  task automatic add_req(input int xi, input int eta, input int mask);
    coord_req_t q;
    q.xi = xi[COORD_W-1:0];
    q.eta = eta[COORD_W-1:0];
    q.mask = mask[MASK_W-1:0];
    req_queue.push_back(q);
  endtask

  function automatic int pick_coord();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 72) begin
      v = int'($urandom_range(0, 32768)) - 16384;
    end else if (sel < 86) begin
      v = 16384 * (int'($urandom_range(0, 2)) - 1);
    end else begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    return v;
  endfunction

  function automatic int pick_mask();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      return 255;
    end else if (sel < 17) begin
      return 0;
    end else if (sel < 25) begin
      return 15;
    end
    return $urandom_range(0, 255);
  endfunction

  // Request driver: a new request is offered only once the previous one has gone.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_nodes(xi_coord_i, eta_coord_i, node_mask_i);
        accepted_reqs++;
      end
      if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        next_req = req_queue.pop_front();
        xi_coord_i <= next_req.xi;
        eta_coord_i <= next_req.eta;
        node_mask_i <= next_req.mask;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_node.node = node_number_o;
        got_node.shape = shape_value_o;
        got_node.dxi = deriv_xi_o;
        got_node.deta = deriv_eta_o;
        got_node.last = last_node_o;
        if (expected_nodes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected result for node %0d", $realtime, node_number_o);
          end
        end else begin
          want_node = expected_nodes.pop_front();
          if (got_node != want_node) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch expected node %0d N %0d dxi %0d deta %0d last %0b",
                       $realtime, want_node.node, $signed(want_node.shape),
                       $signed(want_node.dxi), $signed(want_node.deta), want_node.last);
              $display("%0t:            actual node %0d N %0d dxi %0d deta %0d last %0b",
                       $realtime, got_node.node, $signed(got_node.shape),
                       $signed(got_node.dxi), $signed(got_node.deta), got_node.last);
            end
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  initial begin
    // Directed part: element corners, centre, empty and partial masks, out-of-range points.
    add_req(0, 0, 255);
    add_req(16384, 16384, 255);
    add_req(-16384, -16384, 255);
    add_req(16384, -16384, 255);
    add_req(-16384, 16384, 255);
    add_req(0, 0, 0);
    add_req(0, 0, 15);
    add_req(4096, -8192, 1);
    add_req(-4096, 8192, 128);
    add_req(8192, 8192, 16);
    add_req(32767, 32767, 255);
    add_req(-32768, -32768, 255);
    add_req(-32768, 32767, 255);
    add_req(32767, -32768, 240);
    add_req(8192, -8192, 165);
    add_req(-1, -1, 90);
    add_req(1, 1, 255);
    add_req(16384, 0, 49);
    add_req(0, -16384, 194);
    add_req(-16384, 0, 0);
    for (int k = 0; k < 110; k++) begin
      add_req(pick_coord(), pick_coord(), pick_mask());
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_queue.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_nodes.size() != 0) begin
      @(posedge clk_i);
    end
    // Let any trailing empty-mask request drain, then look for stray results.
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("transition_quad_shape_eval_unit test passed");
    end else begin
      $display("transition_quad_shape_eval_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("transition_quad_shape_eval_unit test failed");
    $finish;
  end

endmodule
